// ===== hdl/tcw_pkg.sv =====
// shared types, constants and helpers of the text console writer
`default_nettype none
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // field widths
    localparam int ADDR_W   = 11;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int CHAR_W   = 8;
    localparam int COLOUR_W = 8;
    localparam int CELL_W   = 16;
    localparam int OP_W     = 2;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [ROW_W-1:0]    t_row;
    typedef logic [COL_W-1:0]    t_col;
    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [COLOUR_W-1:0] t_colour;
    typedef logic [CELL_W-1:0]   t_cell;
    typedef logic [OP_W-1:0]     t_op;

    // operation codes
    localparam t_op OP_PUT   = 2'd0;
    localparam t_op OP_CLEAR = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    // special characters and reset colour
    localparam t_char   CH_NEWLINE   = 8'd10;
    localparam t_char   CH_BACKSPACE = 8'd8;
    localparam t_char   CH_SPACE     = 8'd32;
    localparam t_colour COLOUR_RESET = 8'h0F;

    // fixed cell indexes and row and column limits used by the sweeps, reads and cursor
    localparam t_addr LAST_CELL   = t_addr'(CELLS - 1);
    localparam t_addr NUM_CELLS   = t_addr'(CELLS);
    localparam t_addr BOTTOM_ROW  = t_addr'(CELLS - COLUMNS);
    localparam t_addr ROW_STRIDE  = t_addr'(COLUMNS);
    localparam t_addr READ_AHEAD  = t_addr'(COLUMNS + 1);
    localparam t_addr SCROLL_RD_END = t_addr'(CELLS - COLUMNS - 1);
    localparam t_row  LAST_ROW    = t_row'(ROWS - 1);
    localparam t_col  LAST_COL    = t_col'(COLUMNS - 1);

    typedef struct packed {
        t_op   operation;
        t_char char_byte;
        t_addr cell_address;
    } t_in_item;

    typedef struct packed {
        t_addr cursor_position;
        t_cell cell_value;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL
    } t_state;

    // linear cell index of a row and column
    function automatic t_addr cursor_lin(input t_row row, input t_col col);
        t_addr base;
        base = t_addr'(row) * ROW_STRIDE;
        return base + t_addr'(col);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/text_console_writer_core.sv =====
// Text console writer: 80x25 cell buffer in a simple dual-port RAM, with cursor and scroll.
// An ordinary character, or a backspace outside column 0, writes its cell in the cycle the
// request is accepted; newline and unused codes write no cell. A read goes through the
// registered RAM read port and the ST_READ state before its result is loaded. Clear and a
// scroll each sweep the whole buffer through the single RAM write port; input is held off
// meanwhile. After reset a clearing pass zeroes the whole buffer before the first request
// is taken; colour writes are taken throughout. Each request gives one result; a new
// request is taken only once the result register is free or being emptied.
`default_nettype none
module text_console_writer_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tcw_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tcw_pkg::t_out_item      o_out,
    input  wire logic               i_cfg_wr_en,
    input  wire tcw_pkg::t_colour   i_cfg_wr_data
);

    // cell memory
    tcw_pkg::t_cell r_cells [tcw_pkg::CELLS];

    tcw_pkg::t_state    r_state, n_state;
    tcw_pkg::t_addr     r_idx, n_idx;
    tcw_pkg::t_row      r_row, n_row;
    tcw_pkg::t_col      r_col, n_col;
    tcw_pkg::t_colour   r_colour;
    logic               r_out_valid, n_out_valid;
    tcw_pkg::t_out_item r_out, n_out;
    tcw_pkg::t_cell     r_rdata;
    logic               r_rd_zero, n_rd_zero;

    logic               wr_en;
    tcw_pkg::t_addr     wr_addr;
    tcw_pkg::t_cell     wr_data;
    logic               rd_en;
    tcw_pkg::t_addr     rd_addr;
    logic               in_fire;
    logic               load_out;
    tcw_pkg::t_cell     out_value;
    tcw_pkg::t_cell     blank;
    tcw_pkg::t_addr     cur_lin;
    logic               row_inc;

    assign in_fire = i_in_valid && o_in_ready;
    assign blank   = {r_colour, tcw_pkg::CH_SPACE};
    assign cur_lin = tcw_pkg::cursor_lin(r_row, r_col);

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cells[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_cells[rd_addr];
        end
    end

    // colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour <= tcw_pkg::COLOUR_RESET;
        end else if (i_cfg_wr_en) begin
            r_colour <= i_cfg_wr_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_INIT;
            r_idx       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_rd_zero   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            r_rd_zero   <= n_rd_zero;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // next state, memory port control and result load
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_row     = r_row;
        n_col     = r_col;
        n_rd_zero = r_rd_zero;
        wr_en     = 1'b0;
        wr_addr   = r_idx;
        wr_data   = blank;
        rd_en     = 1'b0;
        rd_addr   = tcw_pkg::ROW_STRIDE;
        load_out  = 1'b0;
        out_value = '0;
        row_inc   = 1'b0;
        o_in_ready = 1'b0;

        case (r_state)
            tcw_pkg::ST_INIT: begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (r_idx == tcw_pkg::LAST_CELL) begin
                    n_idx   = '0;
                    n_state = tcw_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            tcw_pkg::ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (in_fire) begin
                    case (i_in.operation)
                        tcw_pkg::OP_PUT: begin
                            if (i_in.char_byte == tcw_pkg::CH_NEWLINE) begin
                                n_col   = '0;
                                row_inc = 1'b1;
                            end else if (i_in.char_byte == tcw_pkg::CH_BACKSPACE) begin
                                if (r_col != '0) begin
                                    n_col   = r_col - 1'b1;
                                    wr_en   = 1'b1;
                                    wr_addr = cur_lin - 1'b1;
                                    wr_data = blank;
                                end
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = cur_lin;
                                wr_data = {r_colour, i_in.char_byte};
                                if (r_col == tcw_pkg::LAST_COL) begin
                                    n_col   = '0;
                                    row_inc = 1'b1;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                            // past the bottom row starts a scroll sweep
                            if (row_inc && r_row == tcw_pkg::LAST_ROW) begin
                                rd_en   = 1'b1;
                                rd_addr = tcw_pkg::ROW_STRIDE;
                                n_idx   = '0;
                                n_state = tcw_pkg::ST_SCROLL;
                            end else begin
                                if (row_inc) begin
                                    n_row = r_row + 1'b1;
                                end
                                load_out = 1'b1;
                            end
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_idx   = '0;
                            n_state = tcw_pkg::ST_CLEAR;
                        end
                        tcw_pkg::OP_READ: begin
                            n_rd_zero = !(i_in.cell_address < tcw_pkg::NUM_CELLS);
                            rd_en     = !n_rd_zero;
                            rd_addr   = i_in.cell_address;
                            n_state   = tcw_pkg::ST_READ;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end

            tcw_pkg::ST_READ: begin
                load_out  = 1'b1;
                out_value = r_rd_zero ? '0 : r_rdata;
                n_state   = tcw_pkg::ST_IDLE;
            end

            tcw_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = blank;
                if (r_idx == tcw_pkg::LAST_CELL) begin
                    n_idx    = '0;
                    load_out = 1'b1;
                    n_state  = tcw_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            tcw_pkg::ST_SCROLL: begin
                // copy cell idx + COLUMNS down, read one ahead; blank the last row
                wr_en   = 1'b1;
                wr_data = (r_idx < tcw_pkg::BOTTOM_ROW) ? r_rdata : blank;
                rd_en   = r_idx < tcw_pkg::SCROLL_RD_END;
                rd_addr = r_idx + tcw_pkg::READ_AHEAD;
                if (r_idx == tcw_pkg::LAST_CELL) begin
                    n_idx    = '0;
                    load_out = 1'b1;
                    n_state  = tcw_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase

        // result register
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load_out) begin
            n_out_valid           = 1'b1;
            n_out.cursor_position = tcw_pkg::cursor_lin(n_row, n_col);
            n_out.cell_value      = out_value;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== hdl/tcw_checker.sv =====
// port-level checks on the text console writer, bound into text_console_writer_core
`default_nettype none
module tcw_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire tcw_pkg::t_out_item o_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("result changed while stalled");

    // the cursor of a valid result always lies on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.cursor_position < tcw_pkg::NUM_CELLS)
        else $error("cursor off screen");

    // no new request while the result register is full and stalled
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken with result stalled");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
`default_nettype wire
